[hdl/dbia_pkg.sv]
// ----------------------------------------------------------------------------
// Degree bucket id assigner package
// Shared widths, register codes, command codes, controller states and the
// degree bucket classifier used by the id assigner.
// ----------------------------------------------------------------------------
package dbia_pkg;

   localparam int NODE_SLOTS_DEF = 65536;
   localparam int BUCKETS        = 8;
   localparam int BKT_W          = 3;
   localparam int TALLY_W        = 17;
   localparam int ID_W           = 32;
   localparam int AVG_W          = 24;
   localparam int STRIDE_W       = 16;
   localparam int NODE_W         = 16;
   localparam int DEG_W          = 16;

   localparam logic [TALLY_W-1:0]  TALLY_MAX    = 17'h1FFFF;
   localparam logic [AVG_W-1:0]    AVG_RESET    = 24'd256;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd1;

   typedef enum logic [1:0] {
      CMD_CENSUS = 2'd0,
      CMD_BUILD  = 2'd1,
      CMD_MAP    = 2'd2
   } cmd_type;

   typedef enum logic {
      CSR_AVG_DEGREE   = 1'b0,
      CSR_GROUP_STRIDE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BKT,
      ST_TALLY,
      ST_SLOT,
      ST_RD,
      ST_MAP,
      ST_BMUL,
      ST_BOUT
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic clr_we;
      logic tally_inc;
      logic map_assign;
      logic grp_write;
      logic rsp_load;
   } ctrl_type;

   // Buckets are half-open: a degree exactly on a boundary goes to the lower
   // bucket. The degree is scaled by 512 and compared against the average shifted.
   function automatic logic [BKT_W-1:0] bucket_of(input logic [DEG_W-1:0] deg,
                                                  input logic [AVG_W-1:0] avg);
      logic [30:0]      d;
      logic [30:0]      a;
      logic [BKT_W-1:0] b;
      d = {6'd0, deg, 9'd0};
      a = {7'd0, avg};
      b = 3'd7;
      if (d > a)        b = 3'd6;
      if (d > (a << 1)) b = 3'd5;
      if (d > (a << 2)) b = 3'd4;
      if (d > (a << 3)) b = 3'd3;
      if (d > (a << 4)) b = 3'd2;
      if (d > (a << 5)) b = 3'd1;
      if (d > (a << 6)) b = 3'd0;
      return b;
   endfunction

endpackage

[hdl/degree_bucket_id_assigner_top.sv]
// ----------------------------------------------------------------------------
// Degree bucket id assigner
// Renumbers graph nodes by degree bucket: tallies a census, lays out one id
// range per bucket and hands each new node the next id of its bucket.
// ----------------------------------------------------------------------------
// The block works on one beat at a time. After reset it first runs a clearing
// pass over the node map; req_tready stays low until it is done, while
// configuration writes are taken at any time. A census beat runs through the
// bucket and tally states, a map beat through bucket and slot arithmetic, one
// registered memory read, then the update of the map memory, and a build beat
// through a multiply and an output state per group, because the tally times
// stride product is registered before the running start is added. An unused
// command leaves the block idle and produces no beat. Every result beat sits
// in an output register, and a map or build beat waits while it holds a beat
// the consumer has not taken. Because items do not overlap, a map read never
// sees a pending write to the same slot, so the memory needs no forwarding path.

module degree_bucket_id_assigner_top #(
   parameter int NODE_SLOTS = dbia_pkg::NODE_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // node_id [15:0], degree [31:16]
   input  logic [1:0]  req_tuser,   // command [1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // new_id [31:0], group_end [63:32],
                                    // bucket [66:64], is_new [67],
                                    // conflict [68], zero fill [71:69]
   output logic        rsp_tlast,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [23:0] csr_data
);

   // Slot arithmetic. Node ids below 2^16 are reduced modulo NODE_SLOTS by a
   // multiply with the rounded-up reciprocal, which is exact for 16-bit ids.
   localparam int              SLOT_W    = $clog2(NODE_SLOTS);
   localparam bit              NODE_WRAP = NODE_SLOTS < 65536;
   localparam logic [31:0]     RECIP     =
      32'(((64'd1 << 32) + 64'(NODE_SLOTS) - 64'd1) / 64'(NODE_SLOTS));
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NODE_SLOTS - 1);
   localparam logic [dbia_pkg::BKT_W-1:0] GRP_LAST =
      dbia_pkg::BKT_W'(dbia_pkg::BUCKETS - 1);

   dbia_pkg::state_type state_ff, state_in;
   dbia_pkg::ctrl_type  ctrl;
   dbia_pkg::cmd_type   cmd_ff;

   logic [dbia_pkg::AVG_W-1:0]    avg_ff;
   logic [dbia_pkg::STRIDE_W-1:0] stride_ff;

   logic [dbia_pkg::NODE_W-1:0]   node_ff;
   logic [dbia_pkg::DEG_W-1:0]    deg_ff;
   logic [dbia_pkg::BKT_W-1:0]    bucket_ff;
   logic [15:0]                   q_ff;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [SLOT_W-1:0]             clr_cnt_ff;
   logic [dbia_pkg::BKT_W-1:0]    idx_ff;
   logic [dbia_pkg::ID_W-1:0]     start_ff;
   logic [dbia_pkg::ID_W-1:0]     prod_ff;

   logic [dbia_pkg::TALLY_W-1:0]  tally_ff [dbia_pkg::BUCKETS];
   logic [dbia_pkg::ID_W-1:0]     next_ff  [dbia_pkg::BUCKETS];
   logic [dbia_pkg::ID_W-1:0]     limit_ff [dbia_pkg::BUCKETS];

   // Node map: a valid bit memory that the clearing pass resets and an id
   // memory whose read data is only used where the valid bit is set.
   logic                          valid_mem [NODE_SLOTS];
   logic [dbia_pkg::ID_W-1:0]     newid_mem [NODE_SLOTS];
   logic                          vld_rd_ff;
   logic [dbia_pkg::ID_W-1:0]     id_rd_ff;

   logic                          rsp_valid_ff;
   logic [dbia_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [dbia_pkg::ID_W-1:0]     rsp_end_ff, rsp_end_in;
   logic [dbia_pkg::BKT_W-1:0]    rsp_bkt_ff, rsp_bkt_in;
   logic                          rsp_new_ff, rsp_new_in;
   logic                          rsp_conf_ff, rsp_conf_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          req_accept;
   logic                          out_free;
   logic                          clr_last;
   logic [dbia_pkg::BKT_W-1:0]    grp_sel;
   logic [dbia_pkg::TALLY_W-1:0]  tally_sel;
   logic [dbia_pkg::ID_W-1:0]     next_sel;
   logic [dbia_pkg::ID_W-1:0]     limit_sel;
   logic [dbia_pkg::ID_W-1:0]     next_inc;
   logic [dbia_pkg::ID_W-1:0]     lim;
   logic [47:0]                   q_mul;
   logic [31:0]                   rem;
   logic [32:0]                   prod_full;
   logic                          valid_we;
   logic [SLOT_W-1:0]             valid_waddr;
   logic                          tally_nonzero;

   assign req_tready = ctrl.req_ready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clr_last   = clr_cnt_ff == SLOT_LAST;

   // One group index serves the tally, next and limit registers: the build
   // walks the groups in order, census and map use the registered bucket.
   assign grp_sel   = (state_ff == dbia_pkg::ST_BMUL || state_ff == dbia_pkg::ST_BOUT) ?
                      idx_ff : bucket_ff;
   assign tally_sel = tally_ff[grp_sel];
   assign next_sel  = next_ff[grp_sel];
   assign limit_sel = limit_ff[grp_sel];
   assign next_inc  = next_sel + 32'd1;
   assign lim       = start_ff + prod_ff;

   assign q_mul     = 48'(node_ff) * 48'(RECIP);
   assign rem       = 32'(node_ff) - 32'(q_ff) * 32'(NODE_SLOTS);
   assign slot_in   = NODE_WRAP ? SLOT_W'(rem) : SLOT_W'(21'(node_ff));
   assign prod_full = 33'(tally_sel) * 33'(stride_ff);

   always_comb begin
      tally_nonzero = 1'b0;
      for (int i = 0; i < dbia_pkg::BUCKETS; i++) begin
         tally_nonzero = tally_nonzero | (|tally_ff[i]);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbia_pkg::ST_CLEAR: begin
            if (clr_last) state_in = dbia_pkg::ST_IDLE;
         end
         dbia_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  dbia_pkg::CMD_CENSUS, dbia_pkg::CMD_MAP: state_in = dbia_pkg::ST_BKT;
                  dbia_pkg::CMD_BUILD:                     state_in = dbia_pkg::ST_BMUL;
                  default:                                 state_in = dbia_pkg::ST_IDLE;
               endcase
            end
         end
         dbia_pkg::ST_BKT: begin
            state_in = (cmd_ff == dbia_pkg::CMD_MAP) ? dbia_pkg::ST_SLOT : dbia_pkg::ST_TALLY;
         end
         dbia_pkg::ST_TALLY: state_in = dbia_pkg::ST_IDLE;
         dbia_pkg::ST_SLOT:  state_in = dbia_pkg::ST_RD;
         dbia_pkg::ST_RD:    state_in = dbia_pkg::ST_MAP;
         dbia_pkg::ST_MAP: begin
            if (out_free) state_in = dbia_pkg::ST_IDLE;
         end
         dbia_pkg::ST_BMUL:  state_in = dbia_pkg::ST_BOUT;
         dbia_pkg::ST_BOUT: begin
            if (out_free) begin
               state_in = (idx_ff == GRP_LAST) ? dbia_pkg::ST_IDLE : dbia_pkg::ST_BMUL;
            end
         end
         default: state_in = dbia_pkg::ST_IDLE;
      endcase
   end

   // Controls decoded from the state.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         dbia_pkg::ST_CLEAR: ctrl.clr_we    = 1'b1;
         dbia_pkg::ST_IDLE:  ctrl.req_ready = 1'b1;
         dbia_pkg::ST_TALLY: ctrl.tally_inc = 1'b1;
         dbia_pkg::ST_MAP: begin
            ctrl.rsp_load   = out_free;
            ctrl.map_assign = out_free && !vld_rd_ff;
         end
         dbia_pkg::ST_BOUT: begin
            ctrl.rsp_load  = out_free;
            ctrl.grp_write = out_free;
         end
         default: ;
      endcase
   end

   // Result beat contents: a build beat carries one group range, a map beat
   // either the stored id or a freshly assigned one.
   always_comb begin
      if (state_ff == dbia_pkg::ST_BOUT) begin
         rsp_id_in   = start_ff;
         rsp_end_in  = lim;
         rsp_bkt_in  = idx_ff;
         rsp_new_in  = 1'b0;
         rsp_conf_in = 1'b0;
         rsp_last_in = idx_ff == GRP_LAST;
      end else begin
         rsp_id_in   = vld_rd_ff ? id_rd_ff : next_sel;
         rsp_end_in  = '0;
         rsp_bkt_in  = bucket_ff;
         rsp_new_in  = !vld_rd_ff;
         rsp_conf_in = !vld_rd_ff && (next_inc == limit_sel);
         rsp_last_in = 1'b1;
      end
   end

   // Control state, configuration and the per-group registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dbia_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         avg_ff       <= dbia_pkg::AVG_RESET;
         stride_ff    <= dbia_pkg::STRIDE_RESET;
         for (int i = 0; i < dbia_pkg::BUCKETS; i++) begin
            tally_ff[i] <= '0;
            next_ff[i]  <= '0;
            limit_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (ctrl.clr_we) clr_cnt_ff <= clr_cnt_ff + 1'b1;

         if (ctrl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               dbia_pkg::CSR_AVG_DEGREE:   avg_ff    <= csr_data;
               dbia_pkg::CSR_GROUP_STRIDE: stride_ff <= csr_data[15:0];
               default: ;
            endcase
         end

         if (ctrl.tally_inc && tally_sel != dbia_pkg::TALLY_MAX) begin
            tally_ff[grp_sel] <= tally_sel + 1'b1;
         end

         if (ctrl.map_assign) next_ff[grp_sel] <= next_inc;

         if (ctrl.grp_write) begin
            next_ff[grp_sel]  <= start_ff;
            limit_ff[grp_sel] <= lim;
            if (idx_ff == GRP_LAST) begin
               for (int i = 0; i < dbia_pkg::BUCKETS; i++) begin
                  tally_ff[i] <= '0;
               end
            end
         end
      end
   end

   // Item payload and datapath registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= dbia_pkg::cmd_type'(req_tuser);
         node_ff  <= req_tdata[15:0];
         deg_ff   <= req_tdata[31:16];
         idx_ff   <= '0;
         start_ff <= '0;
      end
      if (state_ff == dbia_pkg::ST_BKT) begin
         bucket_ff <= dbia_pkg::bucket_of(deg_ff, avg_ff);
         q_ff      <= q_mul[47:32];
      end
      if (state_ff == dbia_pkg::ST_SLOT) slot_ff <= slot_in;
      if (state_ff == dbia_pkg::ST_BMUL) prod_ff <= prod_full[31:0];
      if (ctrl.grp_write) begin
         start_ff <= lim + 32'd1;
         idx_ff   <= idx_ff + 1'b1;
      end
      if (ctrl.rsp_load) begin
         rsp_id_ff   <= rsp_id_in;
         rsp_end_ff  <= rsp_end_in;
         rsp_bkt_ff  <= rsp_bkt_in;
         rsp_new_ff  <= rsp_new_in;
         rsp_conf_ff <= rsp_conf_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // Node map memories. The write port is shared by the clearing pass and
   // the assignment of a new id; the read data is registered.
   assign valid_we    = ctrl.clr_we || ctrl.map_assign;
   assign valid_waddr = ctrl.clr_we ? clr_cnt_ff : slot_ff;

   always_ff @(posedge clock) begin
      if (valid_we) valid_mem[valid_waddr] <= ctrl.map_assign;
      if (ctrl.map_assign) newid_mem[slot_ff] <= next_sel;
      vld_rd_ff <= valid_mem[slot_ff];
      id_rd_ff  <= newid_mem[slot_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_conf_ff, rsp_new_ff, rsp_bkt_ff, rsp_end_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The map must stay closed to items while its valid bits are being cleared.
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == dbia_pkg::ST_CLEAR |-> !req_tready)
      else $error("item accepted during the clearing pass");

   // A result beat never overwrites one the consumer has not taken.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten");

   // A new id is only assigned where the map read found the slot unmapped.
   a_assign_unmapped: assert property (@(posedge clock) disable iff (reset)
      ctrl.map_assign |-> (state_ff == dbia_pkg::ST_MAP && !vld_rd_ff))
      else $error("id assigned to a mapped slot");

   // The last group of a build leaves every tally cleared.
   a_tally_cleared: assert property (@(posedge clock) disable iff (reset)
      (ctrl.grp_write && idx_ff == GRP_LAST) |=> !tally_nonzero)
      else $error("tallies not cleared after build");

endmodule

[bench/tb_degree_bucket_id_assigner_top.sv]
// ----------------------------------------------------------------------------
// Degree bucket id assigner testbench
// Drives census, build, map and unused command beats into the id assigner.
// A predictor in the bench keeps its own tallies, group ranges and node map,
// and works out the result beats of every accepted request. Each result beat
// is checked field by field against the oldest expected beat. The sender
// works in bursts with random gaps, and the receiver stalls on a changing
// pattern.
// ----------------------------------------------------------------------------
module tb_degree_bucket_id_assigner_top;

   timeunit 1ns;
   timeprecision 1ps;

   // The command encoding leaves one code unused; the block must drop it.
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [16:0] TALLY_CEIL   = 17'h1FFFF;
   localparam int          SETTLE_WAIT  = 24;     // covers a census and spare
   localparam int          DRAIN_LIMIT  = 5000;   // cycles to wait for results
   localparam int          RANDOM_ITEMS = 360;

   // One result beat as the block should present it.
   typedef struct {
      logic [31:0] new_id;
      logic [31:0] group_end;
      logic [2:0]  bucket;
      logic        is_new;
      logic        conflict;
      logic        last;
   } grant_type;

   // Receiver pacing patterns.
   typedef enum int {
      PACE_FULL,
      PACE_COIN,
      PACE_SPARSE,
      PACE_MOSTLY
   } pace_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // node_id [15:0], degree [31:16]
   logic [1:0]  req_tuser = '0;    // command [1:0]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // new_id [31:0], group_end [63:32],
                                   // bucket [66:64], is_new [67],
                                   // conflict [68], zero fill [71:69]
   logic        rsp_tlast;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [23:0] csr_data = '0;

   // Predictor state: the bench's own copy of configuration and tables.
   logic [23:0] avg_cfg    = 24'd256;
   logic [15:0] stride_cfg = 16'd1;
   logic [16:0] bucket_count [8];
   logic [31:0] range_next   [8];
   logic [31:0] range_limit  [8];
   logic [31:0] assigned_id  [int unsigned];   // present only once mapped

   grant_type   due_grants [$];
   int          fault_count = 0;

   // Sender burst control.
   bit          gap_on     = 1'b0;
   int          burst_left = 0;

   // Receiver pacing state.
   pace_type    pace_mode = PACE_FULL;
   int          pace_left = 0;

   degree_bucket_id_assigner_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver switches between pacing patterns, each held for a random stretch.
   // Full pacing gives stretches with no stalls at all; sparse pacing stalls the
   // most, taking a beat only while its countdown is a multiple of eight.
   always @(posedge clock) begin
      if (pace_left == 0) begin
         pace_mode = pace_type'($urandom_range(0, 3));
         pace_left = $urandom_range(16, 96);
      end else begin
         pace_left--;
      end
      case (pace_mode)
         PACE_FULL:   rsp_tready <= 1'b1;
         PACE_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         PACE_SPARSE: rsp_tready <= (pace_left % 8 == 0);
         default:     rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // Place a degree into its half-open bucket. The degree is scaled by 512 so
   // that it lines up with the average's 8 fraction bits times two; each
   // doubling of the average moves the bucket up by one.
   function automatic logic [2:0] degree_bucket(input logic [15:0] deg);
      logic [39:0] scaled;
      logic [39:0] wide_avg;
      logic [2:0]  b;
      int          k;
      scaled   = 40'(deg) << 9;
      wide_avg = 40'(avg_cfg);
      b        = 3'd7;
      for (k = 0; k <= 6; k++) begin
         if (scaled > (wide_avg << k)) b = 3'(6 - k);
      end
      return b;
   endfunction

   // Apply one accepted request to the predictor and queue its result beats.
   function automatic void renumber_item(input logic [1:0] cmd,
                                         input logic [15:0] node,
                                         input logic [15:0] deg);
      logic [2:0]  b;
      logic [31:0] start;
      logic [31:0] lim;
      logic [31:0] id;
      logic [47:0] span;
      int          g;
      b = degree_bucket(deg);
      case (cmd)
         dbia_pkg::CMD_CENSUS: begin
            if (bucket_count[b] != TALLY_CEIL) bucket_count[b]++;
         end
         dbia_pkg::CMD_BUILD: begin
            // Ranges are laid out back to back with one spare id between
            // them; all arithmetic wraps at 32 bits.
            start = '0;
            for (g = 0; g < 8; g++) begin
               span           = 48'(bucket_count[g]) * 48'(stride_cfg);
               lim            = start + span[31:0];
               range_next[g]  = start;
               range_limit[g] = lim;
               due_grants.insert(due_grants.size(),
                                 grant_type'{start, lim, 3'(g), 1'b0, 1'b0, g == 7});
               start          = lim + 32'd1;
            end
            for (g = 0; g < 8; g++) bucket_count[g] = '0;
         end
         dbia_pkg::CMD_MAP: begin
            if (assigned_id.exists(node)) begin
               due_grants.insert(due_grants.size(),
                                 grant_type'{assigned_id[node], '0, b, 1'b0, 1'b0, 1'b1});
            end else begin
               id                = range_next[b];
               range_next[b]     = id + 32'd1;
               assigned_id[node] = id;
               due_grants.insert(due_grants.size(),
                                 grant_type'{id, '0, b, 1'b1,
                                             range_next[b] == range_limit[b], 1'b1});
            end
         end
         default: begin
            // The unused code changes nothing and produces no beat.
         end
      endcase
   endfunction

   // Present one request beat and wait for it to be taken. The valid stays
   // high afterwards so that the next call in the same step can continue a
   // burst; stop_requests lowers it when the bench needs the input idle.
   task automatic send_item(input logic [1:0] cmd, input logic [15:0] node,
                            input logic [15:0] deg);
      if (gap_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {deg, node};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      renumber_item(cmd, node, deg);
   endtask

   task automatic stop_requests();
      req_tvalid <= 1'b0;
   endtask

   // Wait until every expected beat has come, then give the block time to
   // finish any census that produces no beat. Whatever is still expected
   // after the drain limit counts as a fault.
   task automatic settle();
      int waited;
      stop_requests();
      for (waited = 0; waited < DRAIN_LIMIT && due_grants.size() != 0; waited++)
         @(posedge clock);
      if (due_grants.size() != 0) begin
         fault_count++;
         $display("%0t ns: %0d expected result beats never arrived",
                  $time, due_grants.size());
         due_grants.delete();
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Write both registers back to back while the block is idle. The upper
   // byte of the stride write carries noise that the register must ignore.
   task automatic program_config(input logic [23:0] avg, input logic [15:0] stride);
      settle();
      csr_valid <= 1'b1;
      csr_index <= dbia_pkg::CSR_AVG_DEGREE;
      csr_data  <= avg;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      avg_cfg = avg;
      csr_index <= dbia_pkg::CSR_GROUP_STRIDE;
      csr_data  <= {8'($urandom_range(0, 255)), stride};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      stride_cfg = stride;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_degree();
      return 16'($urandom_range(0, 65535) >> $urandom_range(0, 16));
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         $display("%0t ns: %s expected %0h actual %0h", $time, label, want, got);
      end
   endfunction

   // Every result beat taken is matched against the oldest expected beat.
   always @(posedge clock) begin : grant_checker
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_grants.size() == 0) begin
            fault_count++;
            $display("%0t ns: result beat with none expected, new_id %0h",
                     $time, rsp_tdata[31:0]);
         end else begin
            want = due_grants.pop_front();
            check_field("new_id",    want.new_id,    rsp_tdata[31:0]);
            check_field("group_end", want.group_end, rsp_tdata[63:32]);
            check_field("bucket",    32'(want.bucket),   32'(rsp_tdata[66:64]));
            check_field("is_new",    32'(want.is_new),   32'(rsp_tdata[67]));
            check_field("conflict",  32'(want.conflict), 32'(rsp_tdata[68]));
            check_field("last",      32'(want.last),     32'(rsp_tlast));
         end
      end
   end

   // With an average of one, the bucket edges sit at degrees 32, 16, 8, 4, 2
   // and 1; a degree exactly on an edge belongs to the lower bucket. Group 0
   // gets one tallied node, so its first new node hits the range end.
   task automatic test_bucket_boundaries();
      program_config(24'd256, 16'd1);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'd33);
      send_item(dbia_pkg::CMD_CENSUS, 16'hFFFF, 16'd32);
      send_item(dbia_pkg::CMD_CENSUS, 16'h5555, 16'd16);
      send_item(dbia_pkg::CMD_CENSUS, 16'hAAAA, 16'd8);
      send_item(dbia_pkg::CMD_BUILD,  16'h0000, 16'd0);
      send_item(dbia_pkg::CMD_MAP,    16'h0000, 16'd33);
      send_item(dbia_pkg::CMD_MAP,    16'h0001, 16'hFFFF);
      send_item(dbia_pkg::CMD_MAP,    16'hFFFF, 16'd32);
      send_item(dbia_pkg::CMD_MAP,    16'h5555, 16'd16);
      send_item(dbia_pkg::CMD_MAP,    16'hAAAA, 16'd8);
      send_item(dbia_pkg::CMD_MAP,    16'h00FF, 16'd4);
      send_item(dbia_pkg::CMD_MAP,    16'hFF00, 16'd2);
      send_item(dbia_pkg::CMD_MAP,    16'h0F0F, 16'd1);
      send_item(dbia_pkg::CMD_MAP,    16'hF0F0, 16'd0);
      // A node seen before returns its stored id, whatever its degree now.
      send_item(dbia_pkg::CMD_MAP,    16'h0000, 16'd0);
      send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
   endtask

   // A zero average sends every nonzero degree to the top bucket and a zero
   // degree to the bottom one. A zero stride collapses every range.
   task automatic test_zero_average();
      program_config(24'd0, 16'd0);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'd0);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'd1);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'hFFFF);
      send_item(dbia_pkg::CMD_BUILD,  16'h0000, 16'd0);
      send_item(dbia_pkg::CMD_MAP,    16'h1234, 16'd0);
      send_item(dbia_pkg::CMD_MAP,    16'h8001, 16'd1);
      send_item(dbia_pkg::CMD_MAP,    16'h7FFE, 16'hFFFF);
   endtask

   // The largest average keeps every degree in the two lowest buckets; the
   // largest stride stretches their ranges.
   task automatic test_max_average();
      program_config(24'hFFFFFF, 16'hFFFF);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'hFFFF);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'h8000);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'h7FFF);
      send_item(dbia_pkg::CMD_BUILD,  16'h0000, 16'd0);
      send_item(dbia_pkg::CMD_MAP,    16'h3C3C, 16'hFFFF);
      send_item(dbia_pkg::CMD_MAP,    16'hC3C3, 16'h7FFF);
      send_item(dbia_pkg::CMD_MAP,    16'h6666, 16'h8000);
   endtask

   // Tally a run of top-bucket nodes back to back under the largest stride,
   // so that the group ends land far apart, then map into those ranges.
   task automatic test_wide_stride();
      program_config(24'd256, 16'hFFFF);
      gap_on = 1'b0;
      repeat (12) send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'hFFFF);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'd3);
      send_item(dbia_pkg::CMD_CENSUS, 16'h0000, 16'd3);
      send_item(dbia_pkg::CMD_BUILD,  16'h0000, 16'd0);
      send_item(dbia_pkg::CMD_MAP,    16'h2468, 16'hFFFF);
      send_item(dbia_pkg::CMD_MAP,    16'h1357, 16'd3);
      send_item(dbia_pkg::CMD_MAP,    16'h9BDF, 16'd1);
   endtask

   // Phases of census, build and map with random content under a fresh
   // configuration each time, mixed with unused commands, stray census beats
   // and early builds. Map nodes come mostly from a small pool so that known
   // nodes and exhausted ranges show up often.
   task automatic test_random_phases();
      logic [15:0] node_pool [64];
      logic [23:0] avg_pick;
      logic [15:0] stride_pick;
      logic [15:0] node;
      int          counted;
      int          phase_len;
      int          pick;
      int          k;
      for (k = 0; k < 64; k++) node_pool[k] = 16'($urandom_range(0, 65535));
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       avg_pick = 24'd0;
            1:       avg_pick = 24'hFFFFFF;
            2:       avg_pick = 24'd256;
            default: avg_pick = 24'($urandom_range(1, 65535)) << $urandom_range(0, 8);
         endcase
         case ($urandom_range(0, 4))
            0:       stride_pick = 16'd0;
            1:       stride_pick = 16'hFFFF;
            2:       stride_pick = 16'($urandom_range(0, 65535));
            default: stride_pick = 16'($urandom_range(1, 4));
         endcase
         program_config(avg_pick, stride_pick);
         gap_on = ($urandom_range(0, 3) != 0);

         phase_len = $urandom_range(4, 40);
         for (k = 0; k < phase_len; k++) begin
            if ($urandom_range(0, 19) == 0) begin
               send_item(CMD_UNUSED, 16'($urandom), 16'($urandom));
            end else begin
               send_item(dbia_pkg::CMD_CENSUS, 16'($urandom), random_degree());
               counted++;
            end
         end
         send_item(dbia_pkg::CMD_BUILD, 16'($urandom), 16'($urandom));
         counted++;

         phase_len = $urandom_range(4, 40);
         for (k = 0; k < phase_len; k++) begin
            pick = $urandom_range(0, 19);
            node = (pick < 14) ? node_pool[$urandom_range(0, 63)]
                               : 16'($urandom_range(0, 65535));
            if (pick == 0) begin
               send_item(CMD_UNUSED, node, random_degree());
            end else if (pick == 1) begin
               send_item(dbia_pkg::CMD_CENSUS, node, random_degree());
               counted++;
            end else if (pick == 2) begin
               send_item(dbia_pkg::CMD_BUILD, node, random_degree());
               counted++;
            end else begin
               send_item(dbia_pkg::CMD_MAP, node, random_degree());
               counted++;
            end
         end
      end
   endtask

   // Main sequence: reset once, then each test in turn. The block clears its
   // node map after reset and holds off requests until it is done; the send
   // task simply waits on the handshake through that pass.
   initial begin
      foreach (bucket_count[k]) begin
         bucket_count[k] = '0;
         range_next[k]   = '0;
         range_limit[k]  = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_bucket_boundaries();
      test_zero_average();
      test_max_average();
      test_wide_stride();
      test_random_phases();
      settle();

      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // The slowest correct run, dominated by the clearing pass of the node map,
   // ends well inside this bound.
   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
